/* rtl/bscc_pkg.sv */
// shared types and constants for the binary square cover check block
`timescale 1ns / 1ps
`default_nettype none

package bscc_pkg;

    localparam int POS_W     = 7;
    localparam int COORD_W   = 6;
    localparam int COUNT_W   = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic               square_found;
        logic [COORD_W-1:0] square_row;
        logic [COORD_W-1:0] square_col;
        logic               image_done;
        logic               feasible;
        logic [COUNT_W-1:0] square_count;
    } result_t;

    // limit a dimension or position to the range lo..hi
    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] v,
                                                   input logic [POS_W-1:0] lo,
                                                   input logic [POS_W-1:0] hi);
        logic [POS_W-1:0] r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/bscc_core.sv */
// row buffers, 2x2 window detection, coverage tracking and counters
`timescale 1ns / 1ps
`default_nettype none

module bscc_core
    import bscc_pkg::*;
#(
    parameter int MAX_DIM = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic             pixel,
    input  wire logic [POS_W-1:0] image_rows,
    input  wire logic [POS_W-1:0] image_cols,
    output result_t               result
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [POS_W-1:0] DIM_HI = POS_W'(MAX_DIM);
    localparam logic [POS_W-1:0] DIM_LO = POS_W'(2);
    localparam logic [POS_W-1:0] ONE    = POS_W'(1);

    logic [MAX_DIM-1:0] prev_pix_reg, prev_pix_next;
    logic [MAX_DIM-1:0] cur_pix_reg,  cur_pix_next;
    logic [MAX_DIM-1:0] prev_cov_reg, prev_cov_next;
    logic [MAX_DIM-1:0] cur_cov_reg,  cur_cov_next;
    logic               unc_reg,      unc_next;
    logic [POS_W-1:0]   row_reg,      row_next;
    logic [POS_W-1:0]   col_reg,      col_next;
    logic [COUNT_W-1:0] count_reg,    count_next;

    logic [POS_W-1:0]   rows_cl, cols_cl, c, r;
    logic [POS_W-1:0]   c_m1, c_m2, r_m1;
    logic [IDX_W-1:0]   idx_a, idx_b;
    logic [MAX_DIM-1:0] pix_set, win_mask, cur_pix_w, prev_cov_w, cur_cov_w;
    logic               found, row_end, last, unc_w;
    logic [COUNT_W-1:0] count_w;

    always_comb
    begin
        rows_cl = clamp_pos(image_rows, DIM_LO, DIM_HI);
        cols_cl = clamp_pos(image_cols, DIM_LO, DIM_HI);
        c       = clamp_pos(col_reg, ONE, DIM_HI);
        r       = row_reg;
        c_m1    = c - ONE;
        c_m2    = c - POS_W'(2);
        r_m1    = r - ONE;
        idx_a   = c_m1[IDX_W-1:0];
        idx_b   = c_m2[IDX_W-1:0];

        // one-hot of the current column and the two-column window mask
        for (int k = 0; k < MAX_DIM; k++)
        begin
            pix_set[k]  = pixel && (IDX_W'(k) == idx_a);
            win_mask[k] = (c > ONE) && ((IDX_W'(k) == idx_a) || (IDX_W'(k) == idx_b));
        end

        cur_pix_w = cur_pix_reg | pix_set;
        found     = (r > ONE) && (c > ONE) &&
                    prev_pix_reg[idx_a] && prev_pix_reg[idx_b] &&
                    cur_pix_w[idx_a] && cur_pix_w[idx_b];

        prev_cov_w = found ? (prev_cov_reg | win_mask) : prev_cov_reg;
        cur_cov_w  = found ? (cur_cov_reg | win_mask)  : cur_cov_reg;
        count_w    = (found && (count_reg != COUNT_MAX)) ? count_reg + COUNT_W'(1) : count_reg;

        row_end = (c >= cols_cl);
        last    = row_end && (r >= rows_cl);

        // a row is judged when it retires, both rows at the end of the image
        unc_w = unc_reg
              | (row_end && (|(prev_pix_reg & ~prev_cov_w)))
              | (last && (|(cur_pix_w & ~cur_cov_w)));

        result.square_found = found;
        result.square_row   = found ? r_m1[COORD_W-1:0] : '0;
        result.square_col   = found ? c_m1[COORD_W-1:0] : '0;
        result.image_done   = last;
        result.feasible     = last && !unc_w;
        result.square_count = count_w;

        prev_pix_next = prev_pix_reg;
        cur_pix_next  = cur_pix_reg;
        prev_cov_next = prev_cov_reg;
        cur_cov_next  = cur_cov_reg;
        unc_next      = unc_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        count_next    = count_reg;

        if (accept)
        begin
            if (last)
            begin
                prev_pix_next = '0;
                cur_pix_next  = '0;
                prev_cov_next = '0;
                cur_cov_next  = '0;
                unc_next      = 1'b0;
                row_next      = ONE;
                col_next      = ONE;
                count_next    = '0;
            end
            else if (row_end)
            begin
                prev_pix_next = cur_pix_w;
                prev_cov_next = cur_cov_w;
                cur_pix_next  = '0;
                cur_cov_next  = '0;
                unc_next      = unc_w;
                row_next      = r + ONE;
                col_next      = ONE;
                count_next    = count_w;
            end
            else
            begin
                cur_pix_next  = cur_pix_w;
                prev_cov_next = prev_cov_w;
                cur_cov_next  = cur_cov_w;
                unc_next      = unc_w;
                col_next      = c + ONE;
                count_next    = count_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pix_reg <= '0;
            cur_pix_reg  <= '0;
            prev_cov_reg <= '0;
            cur_cov_reg  <= '0;
            unc_reg      <= 1'b0;
            row_reg      <= ONE;
            col_reg      <= ONE;
            count_reg    <= '0;
        end
        else
        begin
            prev_pix_reg <= prev_pix_next;
            cur_pix_reg  <= cur_pix_next;
            prev_cov_reg <= prev_cov_next;
            cur_cov_reg  <= cur_cov_next;
            unc_reg      <= unc_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bscc_out_buf.sv */
// result register with a one-entry skid stage toward the output channel
`timescale 1ns / 1ps
`default_nettype none

module bscc_out_buf
    import bscc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  result_t   in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    take, drain;

    always_comb
    begin
        in_ready  = !skid_valid_reg;
        out_valid = main_valid_reg;
        out_data  = main_reg;
        take      = in_valid && !skid_valid_reg;
        drain     = main_valid_reg && out_ready;

        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;

        if (drain)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (take)
            begin
                main_next = in_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (take)
        begin
            // receiver stalled with a result pending: park the new one
            if (main_valid_reg)
            begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

/* rtl/binary_square_cover_check_top.sv */
// Binary 2x2 square cover check: a binary image streams in one pixel per
// transaction in row-major order on the s_ side. Every pixel yields one result
// on the m_ side: whether it completes an all-ones 2x2 window, that window's
// 1-based top-left row and column, the running window count, and on the last
// pixel of the image (m_tlast) whether every set pixel lies in some window.
// Image size comes from the cfg channel (index 0 rows, 1 columns, 2..MAX_DIM,
// other values clamped); write it only while no pixel is in flight.
// The result is registered before m_tvalid. Throughput is one pixel per cycle
// while the receiver keeps up, set by the single pass through the row-buffer
// window logic between the state registers and the result register.
// Reset clears the row buffers, positions, count and the output stage, and
// sets both dimensions to 64. When the receiver stalls, one more pixel is
// taken into a skid register; s_tready then drops until the stage drains.
// After the last pixel all image state clears and the next pixel starts a
// new image.
`timescale 1ns / 1ps
`default_nettype none

module binary_square_cover_check_top
    import bscc_pkg::*;
#(
    parameter int MAX_DIM = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,    // [0] pixel, [7:1] zero
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,    // [0] square_found, [6:1] square_row,
                                                  // [12:7] square_col, [13] feasible,
                                                  // [25:14] square_count, [31:26] zero
    output logic                      m_tlast,    // image_done
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [POS_W-1:0]     cfg_data
);

    logic [POS_W-1:0] rows_reg, rows_next;
    logic [POS_W-1:0] cols_reg, cols_next;
    logic             accept;
    result_t          core_res;
    result_t          out_res;

    always_comb
    begin
        cfg_ready = 1'b1;
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_ROWS: rows_next = cfg_data;
                REG_IMAGE_COLS: cols_next = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= POS_W'(64);
            cols_reg <= POS_W'(64);
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    bscc_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pixel      (s_tdata[0]),
        .image_rows (rows_reg),
        .image_cols (cols_reg),
        .result     (core_res)
    );

    bscc_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {6'd0, out_res.square_count, out_res.feasible, out_res.square_col,
                      out_res.square_row, out_res.square_found};
    assign m_tlast = out_res.image_done;

endmodule

`default_nettype wire

/* tb/sv/bscc_checker.sv */
// checker for the square cover block: predicts each pixel result and compares the output stream
`timescale 1ns / 1ps

module bscc_checker
    import bscc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [7:0]           s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [31:0]          m_tdata,
    input  wire logic                 m_tlast,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [POS_W-1:0]     cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        images_seen
);

    localparam logic [POS_W-1:0] DIM_MIN = 7'd2;
    localparam logic [POS_W-1:0] DIM_MAX = 7'd64;

    logic [POS_W-1:0]   rows_cfg;
    logic [POS_W-1:0]   cols_cfg;
    logic [63:0]        prev_pix;
    logic [63:0]        cur_pix;
    logic [63:0]        prev_cov;
    logic [63:0]        cur_cov;
    logic               uncovered;
    logic [POS_W-1:0]   row_at;
    logic [POS_W-1:0]   col_at;
    logic [COUNT_W-1:0] win_count;

    result_t expected_results[$];

    function automatic void clear_image();
        prev_pix  = '0;
        cur_pix   = '0;
        prev_cov  = '0;
        cur_cov   = '0;
        uncovered = 1'b0;
        row_at    = 7'd1;
        col_at    = 7'd1;
        win_count = '0;
    endfunction

    // one pixel through the window logic, returns the result it causes
    function automatic result_t predict_pixel(input logic px);
        result_t          res;
        logic [POS_W-1:0] nrows;
        logic [POS_W-1:0] ncols;
        logic [POS_W-1:0] c;
        logic [POS_W-1:0] r;
        logic [63:0]      win;
        logic             last;
        res   = '0;
        nrows = (rows_cfg < DIM_MIN) ? DIM_MIN : (rows_cfg > DIM_MAX) ? DIM_MAX : rows_cfg;
        ncols = (cols_cfg < DIM_MIN) ? DIM_MIN : (cols_cfg > DIM_MAX) ? DIM_MAX : cols_cfg;
        r = row_at;
        c = col_at;
        if (c < 7'd1)
        begin
            c = 7'd1;
        end
        if (c > DIM_MAX)
        begin
            c = DIM_MAX;
        end
        if (px)
        begin
            cur_pix[6'(c - 7'd1)] = 1'b1;
        end
        if (r > 7'd1 && c > 7'd1)
        begin
            win = 64'd3 << 6'(c - 7'd2);
            if ((prev_pix & win) == win && (cur_pix & win) == win)
            begin
                res.square_found = 1'b1;
                res.square_row   = COORD_W'(r - 7'd1);
                res.square_col   = COORD_W'(c - 7'd1);
                prev_cov         = prev_cov | win;
                cur_cov          = cur_cov | win;
                if (win_count != COUNT_MAX)
                begin
                    win_count = win_count + 1'b1;
                end
            end
        end
        last = (r >= nrows) && (c >= ncols);
        if (c >= ncols)
        begin
            // row retires: uncovered set pixels in the older row, at the end in either, miss
            if ((prev_pix & ~prev_cov) != '0)
            begin
                uncovered = 1'b1;
            end
            if (last && (cur_pix & ~cur_cov) != '0)
            begin
                uncovered = 1'b1;
            end
            prev_pix = cur_pix;
            prev_cov = cur_cov;
            cur_pix  = '0;
            cur_cov  = '0;
            col_at   = 7'd1;
            row_at   = r + 7'd1;
        end
        else
        begin
            col_at = c + 7'd1;
        end
        res.square_count = win_count;
        if (last)
        begin
            res.image_done = 1'b1;
            res.feasible   = !uncovered;
            clear_image();
        end
        return res;
    endfunction

    function automatic int field_differs(input string label, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        int      bad;
        int      done_now;
        bad      = 0;
        done_now = 0;
        if (!rst_n)
        begin
            rows_cfg = DIM_MAX;
            cols_cfg = DIM_MAX;
            clear_image();
            expected_results.delete();
            errors      <= 0;
            pending     <= 0;
            images_seen <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_ROWS)
                begin
                    rows_cfg = cfg_data;
                end
                else if (cfg_index == REG_IMAGE_COLS)
                begin
                    cols_cfg = cfg_data;
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.insert(expected_results.size(), predict_pixel(s_tdata[0]));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected, tdata %h tlast %b",
                             $time, m_tdata, m_tlast);
                    bad++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad += field_differs("square_found", want.square_found, m_tdata[0]);
                    bad += field_differs("square_row", want.square_row, m_tdata[6:1]);
                    bad += field_differs("square_col", want.square_col, m_tdata[12:7]);
                    bad += field_differs("image_done", want.image_done, m_tlast);
                    bad += field_differs("feasible", want.feasible, m_tdata[13]);
                    bad += field_differs("square_count", want.square_count, m_tdata[25:14]);
                    bad += field_differs("tdata padding", 0, m_tdata[31:26]);
                    done_now = want.image_done;
                end
            end
            errors      <= errors + bad;
            pending     <= expected_results.size();
            images_seen <= images_seen + done_now;
        end
    end

endmodule

/* tb/sv/tb.sv */
// testbench top for the square cover block: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import bscc_pkg::*;

    localparam int MAX_DIM  = 64;
    localparam int LIMIT_NS = 2_000_000;
    localparam int RANDOM_PIXELS = 1150;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POS_W-1:0]     cfg_data  = '0;

    int errors;
    int pending;
    int images_seen;

    bit calm;
    int pixels_sent;
    int cfg_writes;
    int cur_rows;
    int cur_cols;
    bit img [0:MAX_DIM-1][0:MAX_DIM-1];

    binary_square_cover_check_top #(.MAX_DIM(MAX_DIM)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bscc_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .images_seen (images_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #LIMIT_NS;
        $display("timeout with %0d results still expected", pending);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver stalls at random except during the calm stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 24);
    endfunction

    function automatic int eff_dim(input int raw);
        return (raw < 2) ? 2 : (raw > MAX_DIM) ? MAX_DIM : raw;
    endfunction

    task automatic send_pixel(input bit px);
        while (idle_now())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, px};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_writes++;
    endtask

    // wait for the pipeline to empty, then write both dimensions
    task automatic set_dims(input logic [POS_W-1:0] rows, input logic [POS_W-1:0] cols);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
        write_reg(REG_IMAGE_ROWS, rows);
        write_reg(REG_IMAGE_COLS, cols);
        cfg_valid <= 1'b0;
        cur_rows = eff_dim(rows);
        cur_cols = eff_dim(cols);
    endtask

    // kinds: union of squares, squares with one flipped pixel, random density, flat
    task automatic send_image(input int kind, input int npix);
        int nr;
        int nc;
        int n;
        int rr;
        int cc;
        int p;
        nr = cur_rows;
        nc = cur_cols;
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                img[i][j] = 1'b0;
            end
        end
        if (kind <= 1)
        begin
            n = $urandom_range(1, nr * nc / 2);
            repeat (n)
            begin
                rr = $urandom_range(0, nr - 2);
                cc = $urandom_range(0, nc - 2);
                img[rr][cc]         = 1'b1;
                img[rr][cc + 1]     = 1'b1;
                img[rr + 1][cc]     = 1'b1;
                img[rr + 1][cc + 1] = 1'b1;
            end
            if (kind == 1)
            begin
                rr = $urandom_range(0, nr - 1);
                cc = $urandom_range(0, nc - 1);
                img[rr][cc] = !img[rr][cc];
            end
        end
        else
        begin
            p = (kind == 2) ? $urandom_range(0, 100) : 100 * $urandom_range(0, 1);
            for (int i = 0; i < nr; i++)
            begin
                for (int j = 0; j < nc; j++)
                begin
                    img[i][j] = ($urandom_range(0, 99) < p);
                end
            end
        end
        for (int k = 0; k < npix; k++)
        begin
            send_pixel(img[k / nc][k % nc]);
        end
    endtask

    task automatic send_bits(input bit [3:0] bits);
        for (int k = 0; k < 4; k++)
        begin
            send_pixel(bits[k]);
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int mode;
        int rows_raw;
        int cols_raw;
        int kind;
        int shots;
        calm        = 1'b0;
        pixels_sent = 0;
        cfg_writes  = 0;
        cur_rows    = MAX_DIM;
        cur_cols    = MAX_DIM;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset size 64x64, then shrink mid-image so the current column is past the new width
        send_bits(4'b1111);
        set_dims(7'd2, 7'd3);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b1);
        send_pixel(1'b0);
        // sizes below range act as 2x2: full square, missing corner, then empty, lone pixel
        set_dims(7'd1, 7'd0);
        send_bits(4'b1111);
        send_bits(4'b0111);
        set_dims(7'd2, 7'd2);
        send_bits(4'b0000);
        send_bits(4'b1000);

        // extreme shapes: tallest and widest, the latter through clamping
        set_dims(7'd64, 7'd2);
        send_image(0, cur_rows * cur_cols);
        set_dims(7'd2, 7'd127);
        send_image(1, cur_rows * cur_cols);

        phase = 0;
        while (pixels_sent < RANDOM_PIXELS)
        begin
            calm = (phase >= 8 && phase < 12);
            mode = $urandom_range(0, 19);
            if (mode == 0)
            begin
                rows_raw = $urandom_range(33, 127);
                cols_raw = 2;
            end
            else if (mode == 1)
            begin
                rows_raw = 2;
                cols_raw = $urandom_range(33, 127);
            end
            else
            begin
                rows_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                       : $urandom_range(2, 8);
                cols_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                         : ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16)
                                                       : $urandom_range(2, 8);
            end
            set_dims(POS_W'(rows_raw), POS_W'(cols_raw));
            shots = (mode <= 1) ? 1 : $urandom_range(1, 3);
            repeat (shots)
            begin
                kind = $urandom_range(0, 9);
                kind = (kind <= 5) ? 0 : (kind <= 7) ? 1 : (kind == 8) ? 2 : 3;
                send_image(kind, cur_rows * cur_cols);
            end
            // now and then leave an image unfinished across the next size change
            if ($urandom_range(0, 9) == 0)
            begin
                send_image(2, $urandom_range(1, cur_rows * cur_cols - 1));
            end
            phase++;
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        $display("run covered %0d pixels, %0d register writes, %0d finished images",
                 pixels_sent, cfg_writes, images_seen);
        $display("sizes from 2 to 64 per side with clamped values and a mid-image resize");
        if (errors == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
